>>> rtl/cbf_pkg.sv
// Shared constants, codes and control/status types for the circular byte FIFO.
package cbf_pkg;

  localparam int DEPTH   = 1024;
  localparam int MAX_POP = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POP_W   = $clog2(MAX_POP + 1);
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic push_go;  // accepted push item
    logic pop_go;   // accepted pop request
    logic rd_go;    // read one byte and emit it
    logic rd_last;  // this read ends the run
    logic cfg_wr;   // size register transfer
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [POP_W-1:0] pop_cnt;  // bytes the pending pop will return
  } dp_stat_t;

endpackage

>>> rtl/circular_byte_fifo.sv
// Top level: byte ring buffer with configurable size, block push and burst pop.
//
// Usage:
//  - Input channel: an item transfers at a rising edge with start high and
//    busy low. in_cmd selects push (one byte) or pop (in_length bytes wanted).
//    A push block's first item sets in_first and carries the block length;
//    a block longer than the free space is dropped byte by byte.
//  - Result channel: each result sits on the out_ ports for one cycle with
//    out_valid high. The receiver cannot stall; results are never held.
//  - Config channel: cfg_data transfers when cfg_valid and cfg_ready are
//    high. cfg_ready is high when no pop run is active and start is low.
//    A size write empties the buffer; 0 acts as 1, values above 1024 act
//    as 1024.
//  - Latency: a push result appears the cycle after its transfer, and busy
//    stays low, so pushes go in at one per cycle.
//  - A pop returning bytes holds busy while its run reads them from the
//    store, one byte per cycle; each result is registered from its read,
//    last set on the final one. A pop that returns nothing answers in the
//    cycle after the transfer and busy stays low.
//  - Reset (rst_n low, synchronous): size 1024, buffer empty, no result.
module circular_byte_fifo import cbf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic               in_first,
  input  logic [CNT_W-1:0]   in_length,
  input  logic [BYTE_W-1:0]  in_push_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_data,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [BYTE_W-1:0]  out_data_byte,
  output logic               out_data_valid,
  output logic               out_last,
  output logic [CNT_W-1:0]   out_free_count,
  output logic [CNT_W-1:0]   out_avail_count
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencing: accepts, pop run counter, config handshake
  cbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .busy      (busy),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // storage, pointer arithmetic and registered results
  cbf_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .in_first        (in_first),
    .in_length       (in_length),
    .in_push_byte    (in_push_byte),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_data_byte   (out_data_byte),
    .out_data_valid  (out_data_valid),
    .out_last        (out_last),
    .out_free_count  (out_free_count),
    .out_avail_count (out_avail_count)
  );

endmodule

>>> rtl/cbf_datapath.sv
// Datapath: byte store, indexes, counts, size register and result registers.
module cbf_datapath import cbf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               in_first,
  input  logic [CNT_W-1:0]   in_length,
  input  logic [BYTE_W-1:0]  in_push_byte,
  input  logic [CNT_W-1:0]   cfg_data,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [BYTE_W-1:0]  out_data_byte,
  output logic               out_data_valid,
  output logic               out_last,
  output logic [CNT_W-1:0]   out_free_count,
  output logic [CNT_W-1:0]   out_avail_count
);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  size_r, size_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]  stored_r, stored_nxt;
  logic              rej_r, rej_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;
  logic              odv_r, odv_nxt;
  logic              olast_r, olast_nxt;
  logic [CNT_W-1:0]  ofree_r, ofree_nxt;
  logic [CNT_W-1:0]  oavail_r, oavail_nxt;
  logic [BYTE_W-1:0] rd_data_r;

  logic [CNT_W-1:0]  free_cnt;
  logic              rej_now;
  logic              push_ok;
  logic [CNT_W-1:0]  len_sat;
  logic [CNT_W-1:0]  pop_n;
  logic [CNT_W-1:0]  wr_inc, rd_inc;
  logic [CNT_W-1:0]  cfg_clamped;

  always_comb begin
    free_cnt = size_r - stored_r;
    rej_now  = in_first ? (in_length > free_cnt) : rej_r;
    push_ok  = !rej_now && (stored_r < size_r);

    len_sat = (in_length > CNT_W'(MAX_POP)) ? CNT_W'(MAX_POP) : in_length;
    pop_n   = (len_sat > stored_r) ? stored_r : len_sat;
    stat.pop_cnt = pop_n[POP_W-1:0];

    wr_inc = {1'b0, wr_idx_r} + CNT_W'(1);
    rd_inc = {1'b0, rd_idx_r} + CNT_W'(1);

    // 0 acts as 1, anything above the store depth acts as the depth
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_data > CNT_W'(DEPTH)) begin
      cfg_clamped = CNT_W'(DEPTH);
    end else begin
      cfg_clamped = cfg_data;
    end

    size_nxt   = size_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    stored_nxt = stored_r;
    rej_nxt    = rej_r;
    ovalid_nxt = 1'b0;
    ostat_nxt  = ostat_r;
    odv_nxt    = odv_r;
    olast_nxt  = olast_r;
    ofree_nxt  = ofree_r;
    oavail_nxt = oavail_r;

    if (cmd.cfg_wr) begin
      size_nxt   = cfg_clamped;
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      stored_nxt = '0;
      rej_nxt    = 1'b0;
    end else if (cmd.push_go) begin
      rej_nxt    = rej_now;
      ovalid_nxt = 1'b1;
      odv_nxt    = 1'b0;
      olast_nxt  = 1'b1;
      if (push_ok) begin
        wr_idx_nxt = (wr_inc >= size_r) ? '0 : wr_inc[IDX_W-1:0];
        stored_nxt = stored_r + CNT_W'(1);
        ostat_nxt  = STAT_OK;
        ofree_nxt  = free_cnt - CNT_W'(1);
        oavail_nxt = stored_r + CNT_W'(1);
      end else begin
        ostat_nxt  = STAT_NO_SPACE;
        ofree_nxt  = free_cnt;
        oavail_nxt = stored_r;
      end
    end else if (cmd.pop_go) begin
      // a pop with nothing to return answers without a read run
      if (pop_n == '0) begin
        ovalid_nxt = 1'b1;
        ostat_nxt  = (stored_r == '0) ? STAT_EMPTY : STAT_OK;
        odv_nxt    = 1'b0;
        olast_nxt  = 1'b1;
        ofree_nxt  = free_cnt;
        oavail_nxt = stored_r;
      end
    end else if (cmd.rd_go) begin
      rd_idx_nxt = (rd_inc >= size_r) ? '0 : rd_inc[IDX_W-1:0];
      stored_nxt = stored_r - CNT_W'(1);
      ovalid_nxt = 1'b1;
      ostat_nxt  = STAT_OK;
      odv_nxt    = 1'b1;
      olast_nxt  = cmd.rd_last;
      ofree_nxt  = free_cnt + CNT_W'(1);
      oavail_nxt = stored_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= CNT_W'(DEPTH);
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      stored_r <= '0;
      rej_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      size_r   <= size_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      stored_r <= stored_nxt;
      rej_r    <= rej_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostat_r  <= ostat_nxt;
    odv_r    <= odv_nxt;
    olast_r  <= olast_nxt;
    ofree_r  <= ofree_nxt;
    oavail_r <= oavail_nxt;
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_go && !cmd.cfg_wr && push_ok) begin
      mem[wr_idx_r] <= in_push_byte;
    end
    if (cmd.rd_go) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  assign out_valid       = ovalid_r;
  assign out_status      = ostat_r;
  assign out_data_byte   = odv_r ? rd_data_r : '0;
  assign out_data_valid  = odv_r;
  assign out_last        = olast_r;
  assign out_free_count  = ofree_r;
  assign out_avail_count = oavail_r;

  a_count_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= size_r)
    else $error("stored count above buffer size");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r != '0) && (size_r <= CNT_W'(DEPTH)))
    else $error("buffer size out of range");

  a_read_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_go |-> (stored_r != '0))
    else $error("byte read from empty buffer");

  a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> ((ofree_r + oavail_r) == size_r))
    else $error("free and stored counts do not add up to size");

endmodule

>>> rtl/cbf_ctrl.sv
// Controller: accepts items and sequences the byte reads of a pop run.
module cbf_ctrl import cbf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_cmd,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  output logic      busy,
  input  dp_stat_t  stat,
  output dp_cmd_t   cmd
);

  state_t           state_r, state_nxt;
  logic [POP_W-1:0] rem_r, rem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    cmd         = '0;
    busy        = 1'b0;
    cfg_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // an item on start takes the cycle; the size write waits
        cfg_ready  = !start;
        cmd.cfg_wr = cfg_valid && !start;
        if (start) begin
          if (in_cmd == CMD_POP) begin
            cmd.pop_go = 1'b1;
            if (stat.pop_cnt != '0) begin
              rem_nxt   = stat.pop_cnt;
              state_nxt = ST_POP;
            end
          end else begin
            cmd.push_go = 1'b1;
          end
        end
      end
      ST_POP: begin
        busy        = 1'b1;
        cmd.rd_go   = 1'b1;
        cmd.rd_last = (rem_r == POP_W'(1));
        rem_nxt     = rem_r - POP_W'(1);
        if (rem_r == POP_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_busy_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (rem_r != '0))
    else $error("pop run with no bytes left");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_last |=> (state_r == ST_IDLE))
    else $error("pop run did not end on last byte");

  a_no_cfg_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.cfg_wr)
    else $error("size write during pop run");

endmodule

>>> verif/circular_byte_fifo_test.sv
// Self-checking testbench for circular_byte_fifo: directed cases, then random block traffic.
module circular_byte_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cbf_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int RESET_CYC   = 11;
  // Worst case is far below this: ~290 items, each with at most 64 results
  // plus an idle gap, plus idle time around each size write.
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 32;

  // ---------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic              in_cmd       = CMD_PUSH;
  logic              in_first     = 1'b0;
  logic [CNT_W-1:0]  in_length    = '0;
  logic [BYTE_W-1:0] in_push_byte = '0;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data     = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_data_valid;
  logic              out_last;
  logic [CNT_W-1:0]  out_free_count;
  logic [CNT_W-1:0]  out_avail_count;

  circular_byte_fifo dut (.*);

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ring model: its own copy of the store, pointers, fill level and size
  // register, advanced once per accepted item transfer.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              last;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  avail_count;
  } fifo_reply_t;

  fifo_reply_t       ring_replies[$];   // replies still owed by the DUT, oldest first
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  int                ring_rd         = 0;
  int                ring_wr         = 0;
  int                ring_fill       = 0;
  bit                ring_drop_block = 1'b0;  // current push block was refused
  logic [CNT_W-1:0]  ring_size_reg   = CNT_W'(DEPTH);

  int unsigned cycle_count   = 0;
  int          error_count   = 0;
  bit          steady_stream = 1'b0;  // no gaps between item transfers

  // Size register as the ring uses it: 0 acts as 1, anything above DEPTH as DEPTH.
  function automatic int size_now();
    if (ring_size_reg == '0) return 1;
    if (int'(ring_size_reg) > DEPTH) return DEPTH;
    return int'(ring_size_reg);
  endfunction

  function automatic int bump(input int idx);
    return (idx + 1 >= size_now()) ? 0 : idx + 1;
  endfunction

  // Every reply carries the counts as they stand after it.
  task automatic queue_reply(input logic [STAT_W-1:0] st, input logic [BYTE_W-1:0] b,
                             input logic dv, input logic lst);
    fifo_reply_t r;
    int          sz;
    sz            = size_now();
    r.status      = st;
    r.data_byte   = b;
    r.data_valid  = dv;
    r.last        = lst;
    r.free_count  = CNT_W'((ring_fill <= sz) ? sz - ring_fill : 0);
    r.avail_count = CNT_W'(ring_fill);
    ring_replies.push_back(r);
  endtask

  task automatic ring_step(input logic cmd, input logic first,
                           input logic [CNT_W-1:0] len, input logic [BYTE_W-1:0] pbyte);
    int sz;
    int n;
    sz = size_now();
    if (ring_fill > sz) ring_fill = sz;
    if (cmd == CMD_PUSH) begin
      // The first byte decides for the whole block; length is ignored otherwise.
      if (first) ring_drop_block = (int'(len) > sz - ring_fill);
      if (ring_drop_block || ring_fill >= sz) begin
        queue_reply(STAT_NO_SPACE, '0, 1'b0, 1'b1);
      end else begin
        ring_mem[ring_wr] = pbyte;
        ring_wr           = bump(ring_wr);
        ring_fill++;
        queue_reply(STAT_OK, '0, 1'b0, 1'b1);
      end
    end else begin
      n = int'(len);
      if (n > MAX_POP) n = MAX_POP;
      if (n > ring_fill) n = ring_fill;
      if (n == 0) begin
        // Zero-length pop on a non-empty ring still answers OK, no data.
        queue_reply((ring_fill == 0) ? STAT_EMPTY : STAT_OK, '0, 1'b0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++) begin
          ring_rd = bump(ring_rd);
          ring_fill--;
          queue_reply(STAT_OK, ring_mem[(ring_rd == 0) ? size_now() - 1 : ring_rd - 1],
                      1'b1, (i == n - 1));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    if (steady_stream) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One item transfer. start is left high on return so a back-to-back item
  // keeps it up; whoever stops sending lowers it in the same step.
  task automatic issue_item(input logic cmd, input logic first,
                            input logic [CNT_W-1:0] len, input logic [BYTE_W-1:0] pbyte);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_first     <= first;
    in_length    <= len;
    in_push_byte <= pbyte;
    do @(posedge clk); while (busy);
    ring_step(cmd, first, len, pbyte);
  endtask

  // Size write only with the ring quiet: all replies in, then a few spare cycles.
  task automatic write_size(input logic [CNT_W-1:0] v);
    start <= 1'b0;
    while (ring_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid       <= 1'b0;
    ring_size_reg   = v;
    ring_rd         = 0;
    ring_wr         = 0;
    ring_fill       = 0;
    ring_drop_block = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Reply checker: the receiver cannot stall, so every out_valid cycle is a
  // transfer and is matched against the oldest owed reply.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_replies
    fifo_reply_t want;
    if (rst_n && out_valid) begin
      if (ring_replies.size() == 0) begin
        note_mismatch("result with none pending", 1, 0);
      end else begin
        want = ring_replies.pop_front();
        if (out_status !== want.status)
          note_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_data_byte !== want.data_byte)
          note_mismatch("data_byte", 32'(out_data_byte), 32'(want.data_byte));
        if (out_data_valid !== want.data_valid)
          note_mismatch("data_valid", 32'(out_data_valid), 32'(want.data_valid));
        if (out_last !== want.last)
          note_mismatch("last", 32'(out_last), 32'(want.last));
        if (out_free_count !== want.free_count)
          note_mismatch("free_count", 32'(out_free_count), 32'(want.free_count));
        if (out_avail_count !== want.avail_count)
          note_mismatch("avail_count", 32'(out_avail_count), 32'(want.avail_count));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_byte_fifo verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pops on a freshly emptied ring: both the zero-length and a real request
  // come back as a single EMPTY reply.
  task automatic test_empty_pops();
    write_size(CNT_W'(DEPTH));
    issue_item(CMD_POP, 1'b0, CNT_W'(0), 8'h00);
    issue_item(CMD_POP, 1'b1, CNT_W'(5), 8'hFF);
  endtask

  // Block push of edge bytes, zero-length pop with data stored, saturating
  // pop, oversized block refused byte by byte, then a fitting block clears it.
  task automatic test_block_push_and_drain();
    issue_item(CMD_PUSH, 1'b1, CNT_W'(4), 8'h00);
    issue_item(CMD_PUSH, 1'b0, CNT_W'(2047), 8'hFF);  // length ignored mid-block
    issue_item(CMD_PUSH, 1'b0, CNT_W'(0), 8'hA5);
    issue_item(CMD_PUSH, 1'b0, CNT_W'(1), 8'h5A);
    issue_item(CMD_POP, 1'b0, CNT_W'(0), 8'h00);
    issue_item(CMD_POP, 1'b1, CNT_W'(2047), 8'hFF);
    issue_item(CMD_PUSH, 1'b1, CNT_W'(2047), 8'h11);
    issue_item(CMD_PUSH, 1'b0, CNT_W'(1), 8'h22);
    issue_item(CMD_PUSH, 1'b1, CNT_W'(1), 8'h33);
    issue_item(CMD_POP, 1'b0, CNT_W'(1024), 8'h00);
  endtask

  // Size 0 acts as a one-slot ring: zero-length block fits, then full drops.
  task automatic test_tiny_ring();
    write_size(CNT_W'(0));
    issue_item(CMD_PUSH, 1'b1, CNT_W'(0), 8'h44);
    issue_item(CMD_PUSH, 1'b0, CNT_W'(0), 8'h55);
    issue_item(CMD_PUSH, 1'b1, CNT_W'(1), 8'h66);
    issue_item(CMD_POP, 1'b0, CNT_W'(1), 8'h00);
    issue_item(CMD_POP, 1'b0, CNT_W'(1), 8'h00);
  endtask

  // Three-slot ring: pointers wrap on both sides.
  task automatic test_wraparound();
    write_size(CNT_W'(3));
    issue_item(CMD_PUSH, 1'b1, CNT_W'(3), 8'h01);
    issue_item(CMD_PUSH, 1'b0, CNT_W'(0), 8'h02);
    issue_item(CMD_PUSH, 1'b0, CNT_W'(0), 8'h03);
    issue_item(CMD_POP, 1'b0, CNT_W'(2), 8'h00);
    issue_item(CMD_PUSH, 1'b1, CNT_W'(2), 8'h04);
    issue_item(CMD_PUSH, 1'b0, CNT_W'(0), 8'h05);
    issue_item(CMD_POP, 1'b0, CNT_W'(64), 8'h00);
  endtask

  // Mostly well-formed push blocks and pops with random content, some
  // oversized or cut-short blocks and stray bytes, over several ring sizes.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] sizes [PHASES];
    logic [CNT_W-1:0] pop_len;
    int               sent;
    int               pick;
    int               free_now;
    int               blk;
    int               tail;
    sizes = '{CNT_W'(2047), CNT_W'(1), CNT_W'(2), CNT_W'($urandom_range(3, 16)),
              CNT_W'(1024), CNT_W'($urandom_range(17, 300)),
              CNT_W'($urandom_range(1025, 2047)), CNT_W'($urandom_range(3, 8))};
    for (int p = 0; p < PHASES; p++) begin
      write_size(sizes[p]);
      steady_stream = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick     = $urandom_range(0, 99);
        free_now = size_now() - ring_fill;
        if (pick < 55) begin
          if (free_now > 0 && $urandom_range(0, 99) < 85)
            blk = $urandom_range(1, (free_now < 12) ? free_now : 12);
          else
            blk = $urandom_range(free_now + 1, 2047);
          tail = blk - 1;
          if (blk > free_now)
            tail = (tail < 6) ? tail : $urandom_range(0, 6);  // refused: keep it short
          else if ($urandom_range(0, 9) == 0)
            tail = $urandom_range(0, tail);                   // block cut short
          issue_item(CMD_PUSH, 1'b1, CNT_W'(blk), BYTE_W'($urandom));
          for (int k = 0; k < tail; k++)
            issue_item(CMD_PUSH, 1'b0, CNT_W'($urandom_range(0, 2047)), BYTE_W'($urandom));
          sent += 1 + tail;
        end else if (pick < 88) begin
          pick = $urandom_range(0, 99);
          if (pick < 10)      pop_len = '0;
          else if (pick < 75) pop_len = CNT_W'($urandom_range(1, 20));
          else if (pick < 90) pop_len = CNT_W'($urandom_range(21, 64));
          else                pop_len = CNT_W'($urandom_range(65, 2047));
          issue_item(CMD_POP, 1'($urandom), pop_len, BYTE_W'($urandom));
          sent++;
        end else begin
          // stray push: random first flag, random length
          issue_item(CMD_PUSH, 1'($urandom), CNT_W'($urandom_range(0, 2047)),
                     BYTE_W'($urandom));
          sent++;
        end
      end
    end
    steady_stream = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pops();
    test_block_push_and_drain();
    test_tiny_ring();
    test_wraparound();
    test_random_traffic();
    start <= 1'b0;
    // Drain: the watchdog catches replies that never arrive.
    while (ring_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("circular_byte_fifo verification clean");
    else
      $display("circular_byte_fifo verification failed");
    $finish;
  end

endmodule
